[hw/rtl/ffsa_pkg.sv]
// shared types and constants of the first free slot allocator
`default_nettype none

package ffsa_pkg;

	// fixed field widths of the item channels
	localparam int ACTION_W = 2;
	localparam int OWNER_W  = 16;
	localparam int SLOT_W   = 7;
	localparam int COUNT_W  = 7;
	localparam int CAP_W    = 7;

	// largest slot number that a 7-bit slot or capacity field can reach
	localparam int MAX_REACH = 127;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [OWNER_W-1:0]  owner_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [CAP_W-1:0]    cap_t;

	// action codes, code three is unused
	localparam action_t ACT_RESERVE = 2'd0;
	localparam action_t ACT_RELEASE = 2'd1;
	localparam action_t ACT_QUERY   = 2'd2;

	localparam cap_t CAP_RESET = 7'd64;

endpackage

`default_nettype wire

[hw/rtl/ffsa_if.sv]
// request, response and configuration channel interfaces
`default_nettype none

interface ffsa_req_if;
	logic               valid;
	logic               ready;
	ffsa_pkg::action_t  action;
	ffsa_pkg::owner_t   owner_id;
	ffsa_pkg::slot_t    slot_number;

	modport source (output valid, output action, output owner_id, output slot_number,
		input ready);
	modport sink (input valid, input action, input owner_id, input slot_number,
		output ready);
endinterface

interface ffsa_rsp_if;
	logic               valid;
	logic               ready;
	logic               ok;
	ffsa_pkg::slot_t    granted_slot;
	ffsa_pkg::owner_t   slot_owner;
	ffsa_pkg::count_t   free_count;
	ffsa_pkg::count_t   occupied_count;

	modport source (output valid, output ok, output granted_slot, output slot_owner,
		output free_count, output occupied_count, input ready);
	modport sink (input valid, input ok, input granted_slot, input slot_owner,
		input free_count, input occupied_count, output ready);
endinterface

interface ffsa_cfg_if;
	logic             valid;
	logic             ready;
	ffsa_pkg::cap_t   capacity;

	modport source (output valid, output capacity, input ready);
	modport sink (input valid, input capacity, output ready);
endinterface

`default_nettype wire

[hw/rtl/ffsa_prio.sv]
// lowest set bit priority encoder over the free slot vector
`default_nettype none

module ffsa_prio #(
	parameter int WIDTH = 64,
	parameter int IDX_W = 6
) (
	input  wire logic [WIDTH-1:0] vec,
	output logic                  found,
	output logic [IDX_W-1:0]      idx
);

	always_comb begin
		idx = '0;
		// scan downwards so the lowest set bit wins
		for (int i = WIDTH - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = IDX_W'(i);
			end
		end
	end

	assign found = |vec;

endmodule

`default_nettype wire

[hw/rtl/first_free_slot_allocator_core.sv]
// top level of the first free slot allocator
`default_nettype none

// First free slot allocator. Each request item reserves the lowest free slot
// within the configured capacity for an owner id, releases a numbered slot, or
// queries a slot's owner; each gives exactly one response item with the free
// count within capacity and the total occupied count. An item passes through
// the accept cycle, in which the occupancy flags are searched by a priority
// encoder and the owner table is read or written, and the second stage, which
// holds it while the owner RAM's registered read data becomes available. The
// next item is taken once the second stage has passed its result to the
// output register, so no new item is taken while one is in the second stage.
// The owner table is a single-port style synchronous RAM; one occupancy
// flag per slot, cleared at reset, marks which entries are live, so the RAM
// needs no clearing pass. After each capacity write the block recounts the
// occupied slots inside the new capacity, one slot per cycle over the whole
// table; requests are held off during that recount and while a configuration
// write is offered, configuration writes are always taken.
// Only slots 1 to 127 can be addressed through the 7-bit fields.

module first_free_slot_allocator_core #(
	parameter int SLOTS      = 64,
	parameter int OWNER_BITS = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ffsa_req_if.sink    req,
	ffsa_rsp_if.source  rsp,
	ffsa_cfg_if.sink    cfg
);

	// reachable depth of the table and derived widths
	localparam int DEPTH = (SLOTS < ffsa_pkg::MAX_REACH) ? SLOTS : ffsa_pkg::MAX_REACH;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// configuration and bookkeeping state
	ffsa_pkg::cap_t      capacity_q;
	logic [DEPTH-1:0]    occ_q;          // one flag per slot, set while live
	logic [CNT_W-1:0]    occ_total_q;    // occupied slots in the whole table
	logic [CNT_W-1:0]    incap_q;        // occupied slots inside capacity

	// recount after a capacity write
	logic                sweep_q;
	logic [IDX_W-1:0]    sweep_idx_q;
	logic [CNT_W-1:0]    sweep_acc_q;
	logic [CNT_W-1:0]    sweep_acc_next;

	// owner table
	logic [OWNER_BITS-1:0] owner_mem [DEPTH];
	logic [OWNER_BITS-1:0] rdata_q;

	// second stage
	logic                valid_s1;
	logic                ok_s1;
	ffsa_pkg::slot_t     granted_s1;
	logic                use_mem_s1;
	ffsa_pkg::count_t    free_s1;
	ffsa_pkg::count_t    occ_s1;

	// output register
	logic                out_valid_q;
	logic                ok_q;
	ffsa_pkg::slot_t     granted_q;
	ffsa_pkg::owner_t    owner_q;
	ffsa_pkg::count_t    free_q;
	ffsa_pkg::count_t    occ_q_out;

	// decode of the incoming item
	ffsa_pkg::cap_t        cap_eff;
	logic [DEPTH-1:0]      cap_mask;
	logic [DEPTH-1:0]      free_vec;
	logic                  free_found;
	logic [IDX_W-1:0]      free_idx;
	logic [OWNER_BITS-1:0] owner_m;
	logic                  slot_ok;
	logic [IDX_W-1:0]      slot_idx;
	logic                  slot_live;
	logic                  accept;
	logic                  cfg_write;
	logic                  do_reserve;
	logic                  do_release;
	logic                  do_query;
	logic                  load_out;
	logic [CNT_W-1:0]      total_next;
	logic [CNT_W-1:0]      incap_next;

	// capacity saturates at the reachable depth
	assign cap_eff = (capacity_q > ffsa_pkg::CAP_W'(DEPTH)) ?
		ffsa_pkg::CAP_W'(DEPTH) : capacity_q;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cap_mask[i] = ffsa_pkg::CAP_W'(i) < cap_eff;
		end
	end

	assign free_vec = ~occ_q & cap_mask;

	ffsa_prio #(
		.WIDTH (DEPTH),
		.IDX_W (IDX_W)
	) u_prio (
		.vec   (free_vec),
		.found (free_found),
		.idx   (free_idx)
	);

	// owner is masked to the stored width, zero owner is refused
	assign owner_m   = OWNER_BITS'(req.owner_id);
	assign slot_ok   = (req.slot_number != '0) && (req.slot_number <= cap_eff);
	assign slot_idx  = IDX_W'(req.slot_number - ffsa_pkg::SLOT_W'(1));
	assign slot_live = occ_q[slot_idx];

	// a configuration write takes the cycle, so no item is taken beside it
	assign req.ready = !valid_s1 && !sweep_q && !cfg.valid;
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid && cfg.ready;

	assign do_reserve = (req.action == ffsa_pkg::ACT_RESERVE) && (owner_m != '0) && free_found;
	assign do_release = (req.action == ffsa_pkg::ACT_RELEASE) && slot_ok && slot_live;
	assign do_query   = (req.action == ffsa_pkg::ACT_QUERY) && slot_ok;

	// counts as they stand after this item
	always_comb begin
		total_next = occ_total_q;
		incap_next = incap_q;
		if (do_reserve) begin
			total_next = occ_total_q + CNT_W'(1);
			incap_next = incap_q + CNT_W'(1);
		end else if (do_release) begin
			total_next = occ_total_q - CNT_W'(1);
			incap_next = incap_q - CNT_W'(1);
		end
	end

	assign sweep_acc_next = sweep_acc_q +
		CNT_W'(occ_q[sweep_idx_q] && cap_mask[sweep_idx_q]);

	// owner RAM: write on reserve, read on release or query
	always_ff @(posedge clk) begin
		if (accept && do_reserve) begin
			owner_mem[free_idx] <= owner_m;
		end
		if (accept && (do_release || do_query)) begin
			rdata_q <= owner_mem[slot_idx];
		end
	end

	// configuration, occupancy flags, counters and recount
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= ffsa_pkg::CAP_RESET;
			occ_q       <= '0;
			occ_total_q <= '0;
			incap_q     <= '0;
			sweep_q     <= 1'b0;
			sweep_idx_q <= '0;
			sweep_acc_q <= '0;
		end else if (cfg_write) begin
			capacity_q  <= cfg.capacity;
			sweep_q     <= 1'b1;
			sweep_idx_q <= '0;
			sweep_acc_q <= '0;
		end else if (sweep_q) begin
			sweep_acc_q <= sweep_acc_next;
			if (sweep_idx_q == IDX_W'(DEPTH - 1)) begin
				sweep_q <= 1'b0;
				incap_q <= sweep_acc_next;
			end else begin
				sweep_idx_q <= sweep_idx_q + IDX_W'(1);
			end
		end else if (accept) begin
			occ_total_q <= total_next;
			incap_q     <= incap_next;
			if (do_reserve) begin
				occ_q[free_idx] <= 1'b1;
			end else if (do_release) begin
				occ_q[slot_idx] <= 1'b0;
			end
		end
	end

	// second stage: waits for the RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load_out) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1      <= do_reserve || do_release || do_query;
			granted_s1 <= do_reserve ?
				ffsa_pkg::SLOT_W'(free_idx) + ffsa_pkg::SLOT_W'(1) : '0;
			// a query of a free slot reports owner zero
			use_mem_s1 <= do_release || (do_query && slot_live);
			free_s1    <= cap_eff - ffsa_pkg::COUNT_W'(incap_next);
			occ_s1     <= ffsa_pkg::COUNT_W'(total_next);
		end
	end

	// output register parts the response side from the search
	assign load_out = valid_s1 && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			ok_q      <= ok_s1;
			granted_q <= granted_s1;
			owner_q   <= use_mem_s1 ? ffsa_pkg::OWNER_W'(rdata_q) : '0;
			free_q    <= free_s1;
			occ_q_out <= occ_s1;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.ok             = ok_q;
	assign rsp.granted_slot   = granted_q;
	assign rsp.slot_owner     = owner_q;
	assign rsp.free_count     = free_q;
	assign rsp.occupied_count = occ_q_out;

endmodule

`default_nettype wire

[hw/rtl/ffsa_chk.sv]
// port level checker for the first free slot allocator, bound to the top level
`default_nettype none

module ffsa_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic              rsp_ok,
	input wire ffsa_pkg::slot_t   rsp_granted_slot,
	input wire ffsa_pkg::owner_t  rsp_slot_owner,
	input wire ffsa_pkg::count_t  rsp_free_count,
	input wire ffsa_pkg::count_t  rsp_occupied_count
);

	// one item in flight: no accept in the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken twice in a row");

	// a refused item carries no slot and no owner
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ok) |-> (rsp_granted_slot == '0 && rsp_slot_owner == '0))
		else $error("refused response with slot or owner");

	// a granted slot always comes with ok and with no owner field
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_granted_slot != '0) |-> (rsp_ok && rsp_slot_owner == '0))
		else $error("granted slot without ok");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_ok)
			&& $stable(rsp_granted_slot) && $stable(rsp_slot_owner)
			&& $stable(rsp_free_count) && $stable(rsp_occupied_count)))
		else $error("stalled response changed");

endmodule

bind first_free_slot_allocator_core ffsa_chk u_ffsa_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_ok             (rsp.ok),
	.rsp_granted_slot   (rsp.granted_slot),
	.rsp_slot_owner     (rsp.slot_owner),
	.rsp_free_count     (rsp.free_count),
	.rsp_occupied_count (rsp.occupied_count)
);

`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench of the first free slot allocator core
`timescale 1ns / 100ps

module testbench;

	localparam int TABLE_SLOTS  = 64;
	localparam int MAX_WAIT     = 8;
	localparam int REPORT_MAX   = 10;
	localparam int RANDOM_ITEMS = 800;

	// code three carries no operation, the block answers it with a rejection
	localparam ffsa_pkg::action_t ACT_UNUSED = 2'd3;

	// one response item, in the order of the response channel fields
	typedef struct packed {
		logic             ok;
		ffsa_pkg::slot_t  granted_slot;
		ffsa_pkg::owner_t slot_owner;
		ffsa_pkg::count_t free_count;
		ffsa_pkg::count_t occupied_count;
	} alloc_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ffsa_req_if req_ch ();
	ffsa_rsp_if rsp_ch ();
	ffsa_cfg_if cfg_ch ();

	first_free_slot_allocator_core #(
		.SLOTS      (TABLE_SLOTS),
		.OWNER_BITS (ffsa_pkg::OWNER_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// our own copy of the allocator state: owner per slot, zero when free
	ffsa_pkg::owner_t owner_table [TABLE_SLOTS];
	int               occupied_slots = 0;
	ffsa_pkg::cap_t   capacity_reg   = ffsa_pkg::CAP_RESET;

	// responses still owed by the block, oldest first
	alloc_result_t pending_results [$];
	int mismatch_count = 0;

	// largest idle gap per item on each side, zero gives a stretch with no idling
	int req_gap_max   = MAX_WAIT;
	int rsp_stall_max = MAX_WAIT;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// works out the response of one accepted request and updates the table
	function automatic alloc_result_t predict_allocation(ffsa_pkg::action_t act,
			ffsa_pkg::owner_t owner, ffsa_pkg::slot_t slot);
		alloc_result_t res;
		int usable;
		bit in_range;
		int free_slots;
		res = '0;
		// capacity above the table size saturates
		usable   = (capacity_reg > TABLE_SLOTS) ? TABLE_SLOTS : int'(capacity_reg);
		in_range = (slot >= 1) && (slot <= usable);
		case (act)
			ffsa_pkg::ACT_RESERVE: begin
				// owner zero is refused, otherwise first fit from slot one
				if (owner != '0) begin
					for (int i = 0; i < usable; i++) begin
						if (!res.ok && owner_table[i] == '0) begin
							owner_table[i]   = owner;
							occupied_slots  += 1;
							res.ok           = 1'b1;
							res.granted_slot = ffsa_pkg::slot_t'(i + 1);
						end
					end
				end
			end
			ffsa_pkg::ACT_RELEASE: begin
				// releasing a free slot is refused
				if (in_range && owner_table[slot - 1] != '0) begin
					res.slot_owner          = owner_table[slot - 1];
					owner_table[slot - 1]   = '0;
					occupied_slots         -= 1;
					res.ok                  = 1'b1;
				end
			end
			ffsa_pkg::ACT_QUERY: begin
				// a free slot answers ok with owner zero
				if (in_range) begin
					res.slot_owner = owner_table[slot - 1];
					res.ok         = 1'b1;
				end
			end
			default: begin
				// unused code, counts only
			end
		endcase
		free_slots = 0;
		for (int i = 0; i < usable; i++)
			if (owner_table[i] == '0)
				free_slots++;
		res.free_count     = ffsa_pkg::count_t'(free_slots);
		res.occupied_count = ffsa_pkg::count_t'(occupied_slots);
		return res;
	endfunction

	// sends one request item after a random gap; valid stays high for back-to-back items
	task automatic send_request(ffsa_pkg::action_t act, ffsa_pkg::owner_t owner,
			ffsa_pkg::slot_t slot);
		int gap;
		gap = $urandom_range(0, req_gap_max);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.action      <= act;
		req_ch.owner_id    <= owner;
		req_ch.slot_number <= slot;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		pending_results.push_back(predict_allocation(act, owner, slot));
	endtask

	// stops sending and waits until every owed response has come back
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// capacity is only changed with the block idle
	task automatic write_capacity(ffsa_pkg::cap_t value);
		wait_for_results();
		cfg_ch.valid    <= 1'b1;
		cfg_ch.capacity <= value;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		capacity_reg  = value;
	endtask

	// a fresh table: every slot free, queries answer owner zero
	task automatic test_after_reset();
		send_request(ffsa_pkg::ACT_QUERY, '0, ffsa_pkg::slot_t'(1));
		send_request(ffsa_pkg::ACT_QUERY, 16'hffff, ffsa_pkg::slot_t'(TABLE_SLOTS));
		send_request(ffsa_pkg::ACT_RELEASE, 16'hffff, ffsa_pkg::slot_t'(1));
		send_request(ACT_UNUSED, '0, '0);
	endtask

	// field extremes, refused owner and slot numbers, first fit after a release
	task automatic test_reserve_release();
		send_request(ffsa_pkg::ACT_RESERVE, '0, ffsa_pkg::slot_t'(5));
		send_request(ffsa_pkg::ACT_RESERVE, 16'hffff, '0);
		send_request(ffsa_pkg::ACT_RESERVE, 16'h0001, ffsa_pkg::slot_t'(ffsa_pkg::MAX_REACH));
		send_request(ffsa_pkg::ACT_RESERVE, 16'h8000, '0);
		send_request(ffsa_pkg::ACT_QUERY, 16'h1234, '0);
		send_request(ffsa_pkg::ACT_QUERY, '0, ffsa_pkg::slot_t'(TABLE_SLOTS + 1));
		send_request(ffsa_pkg::ACT_QUERY, '0, ffsa_pkg::slot_t'(ffsa_pkg::MAX_REACH));
		send_request(ffsa_pkg::ACT_RELEASE, '0, '0);
		send_request(ffsa_pkg::ACT_RELEASE, '0, ffsa_pkg::slot_t'(ffsa_pkg::MAX_REACH));
		send_request(ffsa_pkg::ACT_RELEASE, 16'hffff, ffsa_pkg::slot_t'(2));
		send_request(ffsa_pkg::ACT_RELEASE, 16'hffff, ffsa_pkg::slot_t'(2));
		send_request(ffsa_pkg::ACT_RESERVE, 16'h5a5a, ffsa_pkg::slot_t'(9));
		send_request(ffsa_pkg::ACT_QUERY, '0, ffsa_pkg::slot_t'(2));
		send_request(ACT_UNUSED, 16'hffff, ffsa_pkg::slot_t'(ffsa_pkg::MAX_REACH));
	endtask

	// full table, capacity zero, capacity below the live slots and above the table
	task automatic test_capacity_limits();
		write_capacity(ffsa_pkg::cap_t'(3));
		send_request(ffsa_pkg::ACT_RESERVE, 16'h1234, '0);
		write_capacity('0);
		send_request(ffsa_pkg::ACT_RESERVE, 16'h0001, '0);
		send_request(ffsa_pkg::ACT_RELEASE, '0, ffsa_pkg::slot_t'(1));
		send_request(ffsa_pkg::ACT_QUERY, '0, ffsa_pkg::slot_t'(1));
		// slot three keeps its owner but is out of reach
		write_capacity(ffsa_pkg::cap_t'(2));
		send_request(ffsa_pkg::ACT_QUERY, '0, ffsa_pkg::slot_t'(3));
		send_request(ffsa_pkg::ACT_RELEASE, '0, ffsa_pkg::slot_t'(3));
		send_request(ffsa_pkg::ACT_RESERVE, 16'h00aa, '0);
		write_capacity(ffsa_pkg::cap_t'(ffsa_pkg::MAX_REACH));
		send_request(ffsa_pkg::ACT_QUERY, '0, ffsa_pkg::slot_t'(TABLE_SLOTS));
		send_request(ffsa_pkg::ACT_QUERY, '0, ffsa_pkg::slot_t'(TABLE_SLOTS + 1));
		send_request(ffsa_pkg::ACT_RESERVE, 16'h0001, '0);
		write_capacity(ffsa_pkg::CAP_RESET);
	endtask

	// phases of random traffic, each with its own capacity, mix and idling
	task automatic test_random_traffic();
		int sent;
		int phase_len;
		int reserve_pct;
		int usable;
		int roll;
		ffsa_pkg::action_t act;
		ffsa_pkg::owner_t  owner;
		ffsa_pkg::slot_t   slot;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       write_capacity('0);
				1:       write_capacity(ffsa_pkg::cap_t'(1));
				2:       write_capacity(ffsa_pkg::cap_t'(ffsa_pkg::MAX_REACH));
				3:       write_capacity(ffsa_pkg::cap_t'(TABLE_SLOTS + 1));
				4, 5:    write_capacity(ffsa_pkg::cap_t'($urandom_range(2, TABLE_SLOTS - 1)));
				default: write_capacity(ffsa_pkg::cap_t'(TABLE_SLOTS));
			endcase
			case ($urandom_range(0, 3))
				0: begin req_gap_max = 0;        rsp_stall_max = 0;        end
				1: begin req_gap_max = 0;        rsp_stall_max = MAX_WAIT; end
				2: begin req_gap_max = MAX_WAIT; rsp_stall_max = 0;        end
				default: begin req_gap_max = MAX_WAIT; rsp_stall_max = MAX_WAIT; end
			endcase
			usable      = (capacity_reg > TABLE_SLOTS) ? TABLE_SLOTS : int'(capacity_reg);
			phase_len   = (usable == 0) ? 8 : $urandom_range(40, 120);
			reserve_pct = $urandom_range(10, 80);
			for (int n = 0; n < phase_len; n++) begin
				roll  = $urandom_range(0, 99);
				owner = ffsa_pkg::owner_t'($urandom);
				if ($urandom_range(0, 19) == 0)
					owner = '0;
				// mostly a reachable slot, now and then any 7-bit value
				slot = ffsa_pkg::slot_t'($urandom);
				if (usable > 0 && $urandom_range(0, 9) != 0)
					slot = ffsa_pkg::slot_t'($urandom_range(1, usable));
				if (roll >= 97) begin
					act = ACT_UNUSED;
				end else if (roll >= 85) begin
					act = ffsa_pkg::ACT_QUERY;
				end else if (roll < reserve_pct) begin
					act = ffsa_pkg::ACT_RESERVE;
				end else begin
					act = ffsa_pkg::ACT_RELEASE;
					// aim most releases at a live slot
					if (slot >= 1 && slot <= usable)
						for (int k = 0; k < 8 && owner_table[slot - 1] == '0; k++)
							slot = ffsa_pkg::slot_t'($urandom_range(1, usable));
				end
				send_request(act, owner, slot);
			end
			if (usable > 0)
				sent += phase_len;
		end
		req_gap_max   = MAX_WAIT;
		rsp_stall_max = MAX_WAIT;
	endtask

	// response side: random stall before each item, compare against the oldest prediction
	initial begin : response_checker
		int stall;
		alloc_result_t got;
		alloc_result_t want;
		rsp_ch.ready <= 1'b0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.ok             = rsp_ch.ok;
				got.granted_slot   = rsp_ch.granted_slot;
				got.slot_owner     = rsp_ch.slot_owner;
				got.free_count     = rsp_ch.free_count;
				got.occupied_count = rsp_ch.occupied_count;
				if (pending_results.size() == 0) begin
					if (mismatch_count < REPORT_MAX)
						$display("%0t: response item with nothing outstanding: ok=%b slot=%0d owner=%h free=%0d occupied=%0d",
							$time, got.ok, got.granted_slot, got.slot_owner,
							got.free_count, got.occupied_count);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						if (mismatch_count < REPORT_MAX)
							$display("%0t: expected ok=%b slot=%0d owner=%h free=%0d occupied=%0d, got ok=%b slot=%0d owner=%h free=%0d occupied=%0d",
								$time, want.ok, want.granted_slot, want.slot_owner,
								want.free_count, want.occupied_count, got.ok,
								got.granted_slot, got.slot_owner, got.free_count,
								got.occupied_count);
						mismatch_count++;
					end
				end
				stall = $urandom_range(0, rsp_stall_max);
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		req_ch.valid       <= 1'b0;
		req_ch.action      <= ffsa_pkg::ACT_RESERVE;
		req_ch.owner_id    <= '0;
		req_ch.slot_number <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.capacity    <= ffsa_pkg::CAP_RESET;
		for (int i = 0; i < TABLE_SLOTS; i++)
			owner_table[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_reserve_release();
		test_capacity_limits();
		test_random_traffic();
		wait_for_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// hang guard, many times the slowest correct run
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/ffsa_pkg.sv
hw/rtl/ffsa_if.sv
hw/rtl/ffsa_prio.sv
hw/rtl/first_free_slot_allocator_core.sv
hw/rtl/ffsa_chk.sv
tb/sv/testbench.sv
